[hdl/pixel_bits_to_uart_symbols_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for pixel_bits_to_uart_symbols
// Concurrent assertion shorthands clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef PIXEL_BITS_TO_UART_SYMBOLS_ASSERT_SVH
`define PIXEL_BITS_TO_UART_SYMBOLS_ASSERT_SVH

// checked only while out of reset
`define PBU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PBU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pbu_pkg.sv]
// ----------------------------------------------------------------------------
// pbu_pkg
// Types and constants shared by the pixel-bit to UART-symbol encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbu_pkg;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_BIT      = 2'd1,
        MODE_PAIR     = 2'd2,
        MODE_PAIR_ALT = 2'd3
    } mode_t;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYM0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYM1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYM2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYM3  = 3'd5;

    localparam logic [5:0] WIDTH_RESET = 6'd8;

    typedef struct packed {
        mode_t           mode;
        logic [5:0]      value_width;
        logic [3:0][7:0] symbols;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] uart_byte;
        logic       last;
    } sym_t;

endpackage

`default_nettype wire

[hdl/pixel_bits_to_uart_symbols.sv]
// The first byte of a value passes the serializer's input register and then
// the output stage's result register. Throughput: one output byte per cycle
// while out_stall is low; a value yields N symbols (up to MAX_VALUE_WIDTH),
// set by the symbol counter; the next value is taken as the last one goes.
// Values that produce no symbols are taken and dropped. Reset (rst_n low,
// async): outputs invalid, mode MODE_BIT, width 8, symbol bytes zero.
// ----------------------------------------------------------------------------
// pixel_bits_to_uart_symbols
// Encodes intensity values as runs of UART symbol bytes, last byte flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_bits_to_uart_symbols
    import pbu_pkg::*;
#(
    parameter int MAX_VALUE_WIDTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [31:0]          intensity,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                uart_byte,
    output logic                      last_of_value
);

    cfg_t cfg;
    sym_t sym;
    logic sym_ready;

    pbu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbu_serializer #(
        .MAX_VALUE_WIDTH (MAX_VALUE_WIDTH)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .intensity (intensity),
        .sym_ready (sym_ready),
        .sym       (sym)
    );

    pbu_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym           (sym),
        .sym_ready     (sym_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .uart_byte     (uart_byte),
        .last_of_value (last_of_value)
    );

endmodule

`default_nettype wire

[hdl/pbu_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pbu_cfg_regs
// Configuration register file: mode, value width and the four symbol bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_cfg_regs
    import pbu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    output cfg_t                      cfg
);

    mode_t           mode_reg;
    logic [5:0]      width_reg;
    logic [3:0][7:0] sym_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BIT;
            width_reg <= WIDTH_RESET;
            sym_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_WIDTH: width_reg  <= cfg_data[5:0];
                REG_SYM0:  sym_reg[0] <= cfg_data;
                REG_SYM1:  sym_reg[1] <= cfg_data;
                REG_SYM2:  sym_reg[2] <= cfg_data;
                REG_SYM3:  sym_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign cfg.mode        = mode_reg;
    assign cfg.value_width = width_reg;
    assign cfg.symbols     = sym_reg;

endmodule

`default_nettype wire

[hdl/pbu_serializer.sv]
// ----------------------------------------------------------------------------
// pbu_serializer
// Input register for one intensity value plus a down counter of symbols left;
// looks up the symbol of the bit or pair under the counter; pass: low byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_bits_to_uart_symbols_assert.svh"

module pbu_serializer
    import pbu_pkg::*;
#(
    parameter int MAX_VALUE_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] intensity,
    input  wire logic        sym_ready,
    output sym_t             sym
);

    localparam int CNT_W = $clog2(MAX_VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(MAX_VALUE_WIDTH);
    localparam logic [5:0] MAX_W = 6'(MAX_VALUE_WIDTH);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [MAX_VALUE_WIDTH-1:0] data_reg, data_next;

    logic [5:0]       eff_w;
    logic [CNT_W-1:0] load_cnt;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] bit_pos, pair_hi, pair_lo;
    logic [1:0]       sel;
    logic             accept, advance;

    assign eff_w = (cfg.value_width > MAX_W) ? MAX_W : cfg.value_width;

    always_comb
    begin
        unique case (cfg.mode) inside
            MODE_PASS:               load_cnt = CNT_W'(1);
            MODE_BIT:                load_cnt = CNT_W'(eff_w);
            MODE_PAIR, MODE_PAIR_ALT: load_cnt = CNT_W'(eff_w >> 1);
            default:                 load_cnt = '0;
        endcase
    end

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign bit_pos = cnt_m1[IDX_W-1:0];
    assign pair_hi = IDX_W'({cnt_m1, 1'b1});
    assign pair_lo = IDX_W'({cnt_m1, 1'b0});

    always_comb
    begin
        unique case (cfg.mode) inside
            MODE_BIT:                sel = {1'b0, data_reg[bit_pos]};
            MODE_PAIR, MODE_PAIR_ALT: sel = {data_reg[pair_hi], data_reg[pair_lo]};
            default:                 sel = 2'd0;
        endcase
    end

    assign sym.valid     = busy_reg;
    assign sym.uart_byte = (cfg.mode == MODE_PASS) ? data_reg[7:0] : cfg.symbols[sel];
    assign sym.last      = (cnt_reg == CNT_W'(1));

    assign advance  = busy_reg && sym_ready;
    assign in_stall = busy_reg && !(advance && sym.last);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (accept)
        begin
            data_next = intensity[MAX_VALUE_WIDTH-1:0];
            cnt_next  = load_cnt;
            busy_next = (load_cnt != '0);
        end
        else if (advance)
        begin
            cnt_next  = cnt_m1;
            busy_next = !sym.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    `PBU_ASSERT(a_busy_has_count, busy_reg |-> (cnt_reg != '0), "busy with zero count")
    `PBU_ASSERT(a_count_in_range, cnt_reg <= CNT_W'(MAX_VALUE_WIDTH), "count above max width")
    `PBU_ASSERT(a_idle_after_last, (advance && sym.last && !in_valid) |=> !busy_reg,
        "still busy after last symbol")
    `PBU_ASSERT_ALWAYS(a_idle_takes_input, !busy_reg |-> !in_stall, "stalled while idle")

endmodule

`default_nettype wire

[hdl/pbu_out_stage.sv]
// ----------------------------------------------------------------------------
// pbu_out_stage
// Result register on the output channel; frees the serializer while empty or
// while its held transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_out_stage
    import pbu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire sym_t  sym,
    output logic       sym_ready,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [7:0] uart_byte,
    output logic       last_of_value
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    assign sym_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (sym_ready)
        begin
            valid_next = sym.valid;
            byte_next  = sym.uart_byte;
            last_next  = sym.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign uart_byte     = byte_reg;
    assign last_of_value = last_reg;

endmodule

`default_nettype wire
